// File: rtl/tff_pkg.sv
// ----------------------------------------------------------------------------
// Tangent frame package
// Shared types, fixed-point constants and helper functions.
// ----------------------------------------------------------------------------
package tff_pkg;

  typedef logic signed [63:0] wide_t;
  typedef logic signed [31:0] coord_t;
  typedef logic signed [15:0] unit_t;

  localparam int UNIT_FRAC_BITS = 14;
  localparam int NORM_LIMIT_BITS = 30;
  localparam int GS_SHIFT = 28;
  localparam unit_t UNIT_MAX = 16'sh7FFF;
  localparam unit_t UNIT_MIN = 16'sh8000;

  function automatic coord_t sub_sat32(input coord_t a, input coord_t b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    if (d > 33'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (d < -33'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return d[31:0];
  endfunction

  function automatic unit_t neg_sat16(input unit_t a);
    if (a == UNIT_MIN) begin
      return UNIT_MAX;
    end
    return -a;
  endfunction

endpackage

// File: rtl/tff_vertex_if.sv
// ----------------------------------------------------------------------------
// Vertex channel
// Valid/ready channel carrying one vertex item.
// ----------------------------------------------------------------------------
interface tff_vertex_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] tex_u;
  logic signed [31:0] tex_v;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
                output ready);
endinterface

// File: rtl/tff_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one tangent frame item per vertex.
// ----------------------------------------------------------------------------
interface tff_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] tan_x;
  logic signed [15:0] tan_y;
  logic signed [15:0] tan_z;
  logic signed [15:0] out_norm_x;
  logic signed [15:0] out_norm_y;
  logic signed [15:0] out_norm_z;
  logic               last;

  modport source (output valid, tan_x, tan_y, tan_z, out_norm_x, out_norm_y, out_norm_z, last,
                  input ready);
  modport sink (input valid, tan_x, tan_y, tan_z, out_norm_x, out_norm_y, out_norm_z, last,
                output ready);
endinterface

// File: rtl/tff_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the normal source register.
// ----------------------------------------------------------------------------
interface tff_cfg_if;
  logic valid;
  logic ready;
  logic normals_supplied;

  modport source (output valid, normals_supplied, input ready);
  modport sink (input valid, normals_supplied, output ready);
endinterface

// File: rtl/triangle_tangent_frame.sv
// ----------------------------------------------------------------------------
// Triangle tangent frame
// Builds a unit tangent and normal for each vertex of a triangle.
// ----------------------------------------------------------------------------
// Vertex items arrive on the vertex channel, three per triangle. The first
// two are held until the third arrives, which starts the computation and
// yields three result items, in vertex order, with last set on the third.
// The block accepts no vertex until all three results have been taken.
// One 34 x 34 bit multiplier with a 64-bit accumulator forms the determinant,
// the tangent numerator, the face normal cross product, the dot products and
// the Gram-Schmidt terms. A separate normaliser unit does a one-bit-a-cycle
// range shift, a 32-step square root and three 16-step divisions; it runs up
// to five times per triangle. A stalled result holds its value until taken,
// and the sequencer waits. The configuration channel is always ready and
// selects supplied or face normals; write it only while no triangle is in
// progress. Reset clears the vertex count, the mode and the kept tangent.
// ----------------------------------------------------------------------------
module triangle_tangent_frame
  import tff_pkg::*;
(
  input logic           clk,
  input logic           rst,
  tff_vertex_if.sink    vertex,
  tff_result_if.source  result,
  tff_cfg_if.sink       cfg
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CROSS     = 4'd1;
  localparam logic [3:0] S_TAN_GO    = 4'd2;
  localparam logic [3:0] S_TAN_WAIT  = 4'd3;
  localparam logic [3:0] S_FACE_GO   = 4'd4;
  localparam logic [3:0] S_FACE_WAIT = 4'd5;
  localparam logic [3:0] S_DOT       = 4'd6;
  localparam logic [3:0] S_W_GO      = 4'd7;
  localparam logic [3:0] S_W_WAIT    = 4'd8;
  localparam logic [3:0] S_OUT       = 4'd9;

  logic [3:0]  state;
  logic [1:0]  slot;
  logic        mode;
  coord_t      p0 [3];
  coord_t      p1 [3];
  coord_t      uv0 [2];
  coord_t      uv1 [2];
  unit_t       nh0 [3];
  unit_t       nh1 [3];
  unit_t       nh2 [3];
  coord_t      e1 [3];
  coord_t      e2 [3];
  coord_t      du1;
  coord_t      dv1;
  coord_t      du2;
  coord_t      dv2;
  wide_t       res_v [7];
  unit_t       tang [3];
  unit_t       face [3];
  logic signed [33:0] dotv;
  wide_t       acc;
  wide_t       prod;
  logic        phase;
  logic [3:0]  op;
  logic [1:0]  k;
  unit_t       tan_o [3];
  unit_t       norm_o [3];
  logic        last_o;
  logic        out_valid;

  coord_t      pin [3];
  unit_t       nin [3];
  unit_t       nh_k [3];
  unit_t       nsel [3];
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] mul_full;
  wide_t       acc_new;
  logic [1:0]  wi;
  logic        det_zero;
  logic        ustart;
  wide_t       uvec [3];
  unit_t       uq [3];
  logic        udone;

  assign pin[0] = vertex.pos_x;
  assign pin[1] = vertex.pos_y;
  assign pin[2] = vertex.pos_z;
  assign nin[0] = vertex.norm_x;
  assign nin[1] = vertex.norm_y;
  assign nin[2] = vertex.norm_z;

  assign vertex.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign result.valid = out_valid;
  assign result.tan_x = tan_o[0];
  assign result.tan_y = tan_o[1];
  assign result.tan_z = tan_o[2];
  assign result.out_norm_x = norm_o[0];
  assign result.out_norm_y = norm_o[1];
  assign result.out_norm_z = norm_o[2];
  assign result.last = last_o;

  assign det_zero = (res_v[0] == '0);
  assign wi = 2'(op - 4'd3);

  always_comb begin
    case (k)
      2'd0: nh_k = nh0;
      2'd1: nh_k = nh1;
      default: nh_k = nh2;
    endcase
    for (int a = 0; a < 3; a++) begin
      nsel[a] = mode ? neg_sat16(nh_k[a]) : face[a];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_CROSS) begin
      case (op)
        4'd0: begin mul_a = 34'(du1); mul_b = 34'(dv2); end
        4'd1: begin mul_a = 34'(dv1); mul_b = 34'(du2); end
        4'd2: begin mul_a = 34'(e1[0]); mul_b = 34'(dv2); end
        4'd3: begin mul_a = 34'(e2[0]); mul_b = 34'(dv1); end
        4'd4: begin mul_a = 34'(e1[1]); mul_b = 34'(dv2); end
        4'd5: begin mul_a = 34'(e2[1]); mul_b = 34'(dv1); end
        4'd6: begin mul_a = 34'(e1[2]); mul_b = 34'(dv2); end
        4'd7: begin mul_a = 34'(e2[2]); mul_b = 34'(dv1); end
        4'd8: begin mul_a = 34'(e1[1]); mul_b = 34'(e2[2]); end
        4'd9: begin mul_a = 34'(e1[2]); mul_b = 34'(e2[1]); end
        4'd10: begin mul_a = 34'(e1[2]); mul_b = 34'(e2[0]); end
        4'd11: begin mul_a = 34'(e1[0]); mul_b = 34'(e2[2]); end
        4'd12: begin mul_a = 34'(e1[0]); mul_b = 34'(e2[1]); end
        4'd13: begin mul_a = 34'(e1[1]); mul_b = 34'(e2[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else begin
      case (op)
        4'd0: begin mul_a = 34'(nsel[0]); mul_b = 34'(tang[0]); end
        4'd1: begin mul_a = 34'(nsel[1]); mul_b = 34'(tang[1]); end
        4'd2: begin mul_a = 34'(nsel[2]); mul_b = 34'(tang[2]); end
        4'd3: begin mul_a = 34'(nsel[0]); mul_b = dotv; end
        4'd4: begin mul_a = 34'(nsel[1]); mul_b = dotv; end
        4'd5: begin mul_a = 34'(nsel[2]); mul_b = dotv; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  assign mul_full = mul_a * mul_b;

  always_comb begin
    if (state == S_CROSS) begin
      acc_new = op[0] ? acc - prod : prod;
    end else if (op == 4'd0) begin
      acc_new = prod;
    end else if (op < 4'd3) begin
      acc_new = acc + prod;
    end else begin
      acc_new = (wide_t'(tang[wi]) <<< GS_SHIFT) - prod;
    end
  end

  always_comb begin
    ustart = ((state == S_TAN_GO) && !det_zero) || (state == S_FACE_GO) || (state == S_W_GO);
    for (int i = 0; i < 3; i++) begin
      case (state)
        S_TAN_GO: uvec[i] = res_v[0][63] ? -res_v[i+1] : res_v[i+1];
        S_FACE_GO: uvec[i] = res_v[i+4];
        default: uvec[i] = res_v[i];
      endcase
    end
  end

  tff_unitize u_unitize (
    .clk   (clk),
    .rst   (rst),
    .start (ustart),
    .vec   (uvec),
    .comp  (uq),
    .done  (udone)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg.valid) begin
      mode <= cfg.normals_supplied;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot <= 2'd0;
      phase <= 1'b0;
      op <= 4'd0;
      k <= 2'd0;
      out_valid <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        tang[a] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (vertex.valid) begin
            case (slot)
              2'd0: begin
                p0 <= pin;
                nh0 <= nin;
                uv0[0] <= vertex.tex_u;
                uv0[1] <= vertex.tex_v;
                slot <= 2'd1;
              end
              2'd1: begin
                p1 <= pin;
                nh1 <= nin;
                uv1[0] <= vertex.tex_u;
                uv1[1] <= vertex.tex_v;
                slot <= 2'd2;
              end
              default: begin
                for (int a = 0; a < 3; a++) begin
                  e1[a] <= sub_sat32(p1[a], p0[a]);
                  e2[a] <= sub_sat32(pin[a], p0[a]);
                end
                du1 <= sub_sat32(uv1[0], uv0[0]);
                dv1 <= sub_sat32(uv1[1], uv0[1]);
                du2 <= sub_sat32(vertex.tex_u, uv0[0]);
                dv2 <= sub_sat32(vertex.tex_v, uv0[1]);
                nh2 <= nin;
                slot <= 2'd0;
                op <= 4'd0;
                phase <= 1'b0;
                k <= 2'd0;
                state <= S_CROSS;
              end
            endcase
          end
        end
        S_CROSS: begin
          if (!phase) begin
            prod <= mul_full[63:0];
            phase <= 1'b1;
          end else begin
            acc <= acc_new;
            phase <= 1'b0;
            if (op[0]) begin
              res_v[op[3:1]] <= acc_new;
            end
            if (op == 4'd13) begin
              op <= 4'd0;
              state <= S_TAN_GO;
            end else begin
              op <= op + 4'd1;
            end
          end
        end
        S_TAN_GO: begin
          state <= det_zero ? S_FACE_GO : S_TAN_WAIT;
        end
        S_TAN_WAIT: begin
          if (udone) begin
            tang <= uq;
            state <= S_FACE_GO;
          end
        end
        S_FACE_GO: begin
          state <= S_FACE_WAIT;
        end
        S_FACE_WAIT: begin
          if (udone) begin
            face <= uq;
            op <= 4'd0;
            phase <= 1'b0;
            state <= S_DOT;
          end
        end
        S_DOT: begin
          if (!phase) begin
            prod <= mul_full[63:0];
            phase <= 1'b1;
          end else begin
            acc <= acc_new;
            phase <= 1'b0;
            if (op == 4'd2) begin
              dotv <= acc_new[33:0];
            end
            if (op >= 4'd3) begin
              res_v[{1'b0, wi}] <= acc_new;
            end
            if (op == 4'd5) begin
              op <= 4'd0;
              state <= S_W_GO;
            end else begin
              op <= op + 4'd1;
            end
          end
        end
        S_W_GO: begin
          state <= S_W_WAIT;
        end
        S_W_WAIT: begin
          if (udone) begin
            tan_o <= uq;
            norm_o <= nsel;
            last_o <= (k == 2'd2);
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (result.ready) begin
            out_valid <= 1'b0;
            if (k == 2'd2) begin
              k <= 2'd0;
              state <= S_IDLE;
            end else begin
              k <= k + 2'd1;
              op <= 4'd0;
              phase <= 1'b0;
              state <= S_DOT;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/tff_unitize.sv
// ----------------------------------------------------------------------------
// Vector normaliser
// Scales a 64-bit vector to a Q1.14 unit vector with an iterative root and
// divider; a zero vector gives zero.
// ----------------------------------------------------------------------------
module tff_unitize
  import tff_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  wide_t vec [3],
  output unit_t comp [3],
  output logic  done
);

  localparam logic [2:0] U_IDLE  = 3'd0;
  localparam logic [2:0] U_SHIFT = 3'd1;
  localparam logic [2:0] U_SQ    = 3'd2;
  localparam logic [2:0] U_CHK   = 3'd3;
  localparam logic [2:0] U_ROOT  = 3'd4;
  localparam logic [2:0] U_DSET  = 3'd5;
  localparam logic [2:0] U_DIV   = 3'd6;

  logic [2:0]  ustate;
  logic [63:0] mag [3];
  logic        neg [3];
  logic [63:0] sum;
  logic [63:0] rx;
  logic [63:0] rres;
  logic [63:0] rbit;
  logic [31:0] len;
  logic [46:0] rem;
  logic [46:0] dsh;
  logic [15:0] q;
  logic [3:0]  cnt;
  logic [1:0]  idx;

  logic [29:0] mag_sel;
  logic [59:0] sq;
  logic        big;
  logic [63:0] rtry;
  logic [63:0] rres_next;
  logic [63:0] rx_next;
  logic        qbit;
  logic [15:0] qn;
  unit_t       qs;

  assign mag_sel = mag[idx][NORM_LIMIT_BITS-1:0];
  assign sq = mag_sel * mag_sel;
  assign big = (|mag[0][63:NORM_LIMIT_BITS]) || (|mag[1][63:NORM_LIMIT_BITS])
            || (|mag[2][63:NORM_LIMIT_BITS]);
  assign rtry = rres + rbit;
  assign qbit = rem >= dsh;
  assign qn = {q[14:0], qbit};
  assign qs = qn[15] ? UNIT_MAX : unit_t'(qn);

  always_comb begin
    if (rx >= rtry) begin
      rx_next = rx - rtry;
      rres_next = (rres >> 1) + rbit;
    end else begin
      rx_next = rx;
      rres_next = rres >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ustate <= U_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (ustate)
        U_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              neg[i] <= vec[i][63];
              mag[i] <= vec[i][63] ? 64'(-vec[i]) : 64'(vec[i]);
            end
            ustate <= U_SHIFT;
          end
        end
        U_SHIFT: begin
          if (big) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] >> 1;
            end
          end else begin
            idx <= 2'd0;
            sum <= '0;
            ustate <= U_SQ;
          end
        end
        U_SQ: begin
          sum <= sum + 64'(sq);
          if (idx == 2'd2) begin
            ustate <= U_CHK;
          end else begin
            idx <= idx + 2'd1;
          end
        end
        U_CHK: begin
          if (sum == '0) begin
            for (int i = 0; i < 3; i++) begin
              comp[i] <= '0;
            end
            done <= 1'b1;
            ustate <= U_IDLE;
          end else begin
            rx <= sum;
            rres <= '0;
            rbit <= 64'h4000_0000_0000_0000;
            ustate <= U_ROOT;
          end
        end
        U_ROOT: begin
          rx <= rx_next;
          rres <= rres_next;
          rbit <= rbit >> 2;
          if (rbit[0]) begin
            len <= rres_next[31:0];
            idx <= 2'd0;
            ustate <= U_DSET;
          end
        end
        U_DSET: begin
          rem <= 47'({mag_sel, {UNIT_FRAC_BITS{1'b0}}}) + 47'(len >> 1);
          dsh <= 47'(len) << 15;
          q <= '0;
          cnt <= '0;
          ustate <= U_DIV;
        end
        U_DIV: begin
          if (qbit) begin
            rem <= rem - dsh;
          end
          q <= qn;
          dsh <= dsh >> 1;
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            comp[idx] <= neg[idx] ? -qs : qs;
            if (idx == 2'd2) begin
              done <= 1'b1;
              ustate <= U_IDLE;
            end else begin
              idx <= idx + 2'd1;
              ustate <= U_DSET;
            end
          end
        end
        default: begin
          ustate <= U_IDLE;
        end
      endcase
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle tangent frame testbench
// Drives vertex items through a directed table and then random triangles in
// both normal modes and under four idling patterns. Every result item is
// compared with a bit-exact fixed-point model or a typed table row's values.
// ----------------------------------------------------------------------------
module testbench
  import tff_pkg::*;
();

  typedef longint l3_t [3];

  typedef struct {
    coord_t pos [3];
    coord_t tu;
    coord_t tv;
    unit_t  nrm [3];
  } vtx_t;

  typedef struct {
    bit     mode;
    vtx_t   vx;
    bit     typed;
    unit_t  tan [3];
    unit_t  nrm [3];
  } row_t;

  typedef struct {
    unit_t tan [3];
    unit_t nrm [3];
    logic  last;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tff_vertex_if vertex ();
  tff_result_if result ();
  tff_cfg_if    cfg ();

  triangle_tangent_frame dut (
    .clk    (clk),
    .rst    (rst),
    .vertex (vertex.sink),
    .result (result.source),
    .cfg    (cfg.sink)
  );

  always #5 clk = ~clk;

  frame_t frames_due [$];
  int     errors = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;

  bit     model_supplied = 1'b0;
  int     model_slot = 0;
  vtx_t   model_held [2];
  longint model_tangent [3] = '{0, 0, 0};

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic l3_t unit_vector(l3_t v);
    longint unsigned mag [3];
    longint unsigned mx, sum, len, q;
    bit neg [3];
    int sh;
    l3_t r;
    mx = 0;
    sum = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? 64'd0 - longint'(unsigned'(v[i])) : longint'(unsigned'(v[i]));
      if (mag[i] > mx) mx = mag[i];
    end
    while ((mx >> sh) >= (64'd1 << 30)) sh++;
    for (int i = 0; i < 3; i++) begin
      mag[i] >>= sh;
      sum += mag[i] * mag[i];
    end
    if (sum == 0) return '{0, 0, 0};
    len = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 16384 + len / 2) / len;
      if (q > 32767) q = 32767;
      r[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    return r;
  endfunction

  function automatic void predict_frames(vtx_t v, bit typed, unit_t tt [3], unit_t tn [3]);
    vtx_t   t [3];
    longint e1 [3], e2 [3], num [3], fn [3], face [3], n [3], w [3], tg [3];
    longint du1, dv1, du2, dv2, det, dot;
    frame_t f;
    if (model_slot < 2) begin
      model_held[model_slot] = v;
      model_slot++;
      return;
    end
    model_slot = 0;
    t[0] = model_held[0];
    t[1] = model_held[1];
    t[2] = v;
    for (int a = 0; a < 3; a++) begin
      e1[a] = sat32(longint'(t[1].pos[a]) - longint'(t[0].pos[a]));
      e2[a] = sat32(longint'(t[2].pos[a]) - longint'(t[0].pos[a]));
    end
    du1 = sat32(longint'(t[1].tu) - longint'(t[0].tu));
    dv1 = sat32(longint'(t[1].tv) - longint'(t[0].tv));
    du2 = sat32(longint'(t[2].tu) - longint'(t[0].tu));
    dv2 = sat32(longint'(t[2].tv) - longint'(t[0].tv));
    det = du1 * dv2 - dv1 * du2;
    if (det != 0) begin
      for (int a = 0; a < 3; a++) begin
        num[a] = e1[a] * dv2 - e2[a] * dv1;
        if (det < 0) num[a] = -num[a];
      end
      model_tangent = unit_vector(num);
    end
    fn[0] = e1[1] * e2[2] - e1[2] * e2[1];
    fn[1] = e1[2] * e2[0] - e1[0] * e2[2];
    fn[2] = e1[0] * e2[1] - e1[1] * e2[0];
    face = unit_vector(fn);
    for (int k = 0; k < 3; k++) begin
      dot = 0;
      for (int a = 0; a < 3; a++) begin
        if (model_supplied) begin
          n[a] = -longint'(t[k].nrm[a]);
          if (n[a] > 32767) n[a] = 32767;
        end else begin
          n[a] = face[a];
        end
        dot += n[a] * model_tangent[a];
      end
      for (int a = 0; a < 3; a++) w[a] = model_tangent[a] * (64'sd1 <<< 28) - n[a] * dot;
      tg = unit_vector(w);
      for (int a = 0; a < 3; a++) begin
        f.tan[a] = typed ? tt[a] : unit_t'(tg[a]);
        f.nrm[a] = typed ? tn[a] : unit_t'(n[a]);
      end
      f.last = (k == 2);
      frames_due = {frames_due, f};
    end
  endfunction

  task automatic await_drain();
    while (frames_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_mode(bit mode);
    @(negedge clk);
    vertex.valid <= 1'b0;
    await_drain();
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.normals_supplied <= mode;
    do @(posedge clk); while (!cfg.ready);
    model_supplied = mode;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic send_vertex(vtx_t v, bit typed, unit_t tt [3], unit_t tn [3]);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      vertex.valid <= 1'b0;
      @(negedge clk);
    end
    vertex.valid <= 1'b1;
    vertex.pos_x <= v.pos[0];
    vertex.pos_y <= v.pos[1];
    vertex.pos_z <= v.pos[2];
    vertex.tex_u <= v.tu;
    vertex.tex_v <= v.tv;
    vertex.norm_x <= v.nrm[0];
    vertex.norm_y <= v.nrm[1];
    vertex.norm_z <= v.nrm[2];
    do @(posedge clk); while (!vertex.ready);
    predict_frames(v, typed, tt, tn);
  endtask

  function automatic vtx_t mk(coord_t x, coord_t y, coord_t z, coord_t u, coord_t tv,
                              unit_t nx, unit_t ny, unit_t nz);
    vtx_t v;
    v.pos = '{x, y, z};
    v.tu = u;
    v.tv = tv;
    v.nrm = '{nx, ny, nz};
    return v;
  endfunction

  function automatic coord_t rand_coord(bit full);
    if (full) return coord_t'($urandom);
    return coord_t'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
  endfunction

  function automatic unit_t rand_normal();
    case ($urandom_range(3))
      0: return unit_t'($urandom);
      1: return UNIT_MIN;
      default: return unit_t'($urandom_range(0, 32768)) - 16'sd16384;
    endcase
  endfunction

  always @(negedge clk) begin
    result.ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    frame_t f;
    if (!rst && result.valid && result.ready) begin
      if (frames_due.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        f = frames_due.pop_front();
        if (result.tan_x !== f.tan[0]) begin
          $error("tan_x expected %0d got %0d", f.tan[0], result.tan_x); errors++;
        end
        if (result.tan_y !== f.tan[1]) begin
          $error("tan_y expected %0d got %0d", f.tan[1], result.tan_y); errors++;
        end
        if (result.tan_z !== f.tan[2]) begin
          $error("tan_z expected %0d got %0d", f.tan[2], result.tan_z); errors++;
        end
        if (result.out_norm_x !== f.nrm[0]) begin
          $error("out_norm_x expected %0d got %0d", f.nrm[0], result.out_norm_x); errors++;
        end
        if (result.out_norm_y !== f.nrm[1]) begin
          $error("out_norm_y expected %0d got %0d", f.nrm[1], result.out_norm_y); errors++;
        end
        if (result.out_norm_z !== f.nrm[2]) begin
          $error("out_norm_z expected %0d got %0d", f.nrm[2], result.out_norm_z); errors++;
        end
        if (result.last !== f.last) begin
          $error("last expected %0b got %0b", f.last, result.last); errors++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    row_t  rows [18];
    unit_t zr [3];
    vtx_t  tri_v [3];
    coord_t base_u, base_v;
    int    kind;
    localparam coord_t ONE = 32'sh0001_0000;
    localparam coord_t CMAX = 32'sh7FFF_FFFF;
    localparam coord_t CMIN = 32'sh8000_0000;

    zr = '{0, 0, 0};
    vertex.valid = 1'b0;
    vertex.pos_x = '0; vertex.pos_y = '0; vertex.pos_z = '0;
    vertex.tex_u = '0; vertex.tex_v = '0;
    vertex.norm_x = '0; vertex.norm_y = '0; vertex.norm_z = '0;
    cfg.valid = 1'b0;
    cfg.normals_supplied = 1'b0;
    result.ready = 1'b0;

    foreach (rows[i]) begin
      rows[i].mode = (i >= 12);
      rows[i].typed = 1'b0;
      rows[i].tan = zr;
      rows[i].nrm = zr;
    end
    rows[0].vx = mk(0, 0, 0, 0, 0, 0, 0, 0);
    rows[1].vx = mk(0, 0, 0, 0, 0, 0, 0, 0);
    rows[2].vx = mk(0, 0, 0, 0, 0, 0, 0, 0);
    rows[2].typed = 1'b1;
    rows[3].vx = mk(0, 0, 0, 0, 0, 0, 0, 0);
    rows[4].vx = mk(ONE, 0, 0, ONE, 0, 0, 0, 0);
    rows[5].vx = mk(0, ONE, 0, 0, ONE, 0, 0, 0);
    rows[5].typed = 1'b1;
    rows[5].tan = '{16384, 0, 0};
    rows[5].nrm = '{0, 0, 16384};
    rows[6].vx = mk(0, 0, 0, ONE, ONE, 0, 0, 0);
    rows[7].vx = mk(ONE, 0, ONE, ONE, ONE, 0, 0, 0);
    rows[8].vx = mk(0, ONE, 0, ONE, ONE, 0, 0, 0);
    rows[9].vx = mk(CMIN, CMIN, CMIN, CMIN, CMIN, UNIT_MIN, UNIT_MAX, 0);
    rows[10].vx = mk(CMAX, CMAX, CMAX, CMAX, CMAX, UNIT_MAX, UNIT_MIN, 0);
    rows[11].vx = mk(CMAX, CMIN, 0, 0, CMAX, 0, 0, UNIT_MIN);
    rows[12].vx = mk(0, 0, 0, 0, 0, UNIT_MIN, UNIT_MAX, 0);
    rows[13].vx = mk(ONE, 0, 0, ONE, 0, 0, UNIT_MIN, 0);
    rows[14].vx = mk(0, ONE, 0, 0, ONE, 16384, 0, -16384);
    rows[15].vx = mk(ONE, ONE, ONE, 0, 0, 0, 0, 0);
    rows[16].vx = mk(ONE, ONE, ONE, ONE, 0, 0, 0, 0);
    rows[17].vx = mk(ONE, ONE, ONE, 0, ONE, 0, 0, 0);
    rows[17].typed = 1'b1;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].mode != model_supplied) write_mode(rows[i].mode);
      send_vertex(rows[i].vx, rows[i].typed, rows[i].tan, rows[i].nrm);
    end

    for (int ph = 0; ph < 8; ph++) begin
      write_mode(ph[0]);
      send_idle_pct  = (ph / 2 == 1 || ph / 2 == 3) ? 60 : 0;
      recv_stall_pct = (ph / 2 == 2 || ph / 2 == 3) ? 60 : 0;
      if (ph / 2 == 3) begin
        send_idle_pct = 16;
        recv_stall_pct = 16;
      end
      for (int tri_n = 0; tri_n < 8; tri_n++) begin
        kind = $urandom_range(9);
        base_u = rand_coord(kind == 0);
        base_v = rand_coord(kind == 0);
        for (int k = 0; k < 3; k++) begin
          tri_v[k] = mk(rand_coord(kind == 0), rand_coord(kind == 0), rand_coord(kind == 0),
                        rand_coord(kind == 0), rand_coord(kind == 0),
                        rand_normal(), rand_normal(), rand_normal());
          if (kind == 1) begin
            tri_v[k].tu = base_u;
            tri_v[k].tv = base_v;
          end
          if (kind == 2 && k > 0) tri_v[k].pos = tri_v[0].pos;
        end
        for (int k = 0; k < 3; k++) send_vertex(tri_v[k], 1'b0, zr, zr);
      end
    end

    @(negedge clk);
    vertex.valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    await_drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tff_pkg.sv
rtl/tff_vertex_if.sv
rtl/tff_result_if.sv
rtl/tff_cfg_if.sv
rtl/tff_unitize.sv
rtl/triangle_tangent_frame.sv
dv/testbench.sv
